// ===== hw/rtl/persymmetric_triangular_matvec_macros.svh =====
// assertion helpers used by the top-level rtl file
`ifndef PERSYMMETRIC_TRIANGULAR_MATVEC_MACROS_SVH
`define PERSYMMETRIC_TRIANGULAR_MATVEC_MACROS_SVH

// clocked assertion, ignored while reset is asserted
`define PTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PTM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ptm_pkg.sv =====
package ptm_pkg;

  localparam int MAX_N  = 16;
  localparam int IDX_W  = $clog2(MAX_N);
  localparam int N_W    = IDX_W + 1;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = MAX_N * MAX_N;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int DOT_W  = 36;

  typedef enum logic [1:0] {
    ACT_LOAD_MAT = 2'd0,
    ACT_LOAD_VEC = 2'd1,
    ACT_COMPUTE  = 2'd2
  } action_t;

  // per-column control that travels with the matrix and vector operands
  typedef struct packed {
    logic             mac;
    logic             first;
    logic             lastcol;
    logic             lastrow;
    logic [IDX_W-1:0] row;
  } tag_t;

  // finished row result
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [DOT_W-1:0] dot;
  } res_t;

endpackage

// ===== hw/rtl/ptm_vec_cell.sv =====
module ptm_vec_cell import ptm_pkg::*; (
  input  logic             clk,
  input  logic             load_en,
  input  logic [VAL_W-1:0] load_val,
  input  logic             shift_en,
  input  logic [VAL_W-1:0] shift_in,
  output logic [VAL_W-1:0] val
);

  logic [VAL_W-1:0] val_r;

  // direct load from the input channel, else take the neighbor's element
  always_ff @(posedge clk) begin
    if (load_en) begin
      val_r <= load_val;
    end else if (shift_en) begin
      val_r <= shift_in;
    end
  end

  assign val = val_r;

endmodule

// ===== hw/rtl/ptm_mac.sv =====
module ptm_mac import ptm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    op_valid,
  input  tag_t                    op_tag,
  input  logic signed [VAL_W-1:0] op_mat,
  input  logic signed [VAL_W-1:0] op_vec,
  output res_t                    res
);

  logic                     s2_v_r;
  tag_t                     tag2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DOT_W-1:0]  acc_r;
  logic signed [DOT_W-1:0]  prod_ext;
  logic signed [DOT_W-1:0]  acc_sum;

  // multiply stage, zero for elements above the diagonal or beyond n
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag2_r <= op_tag;
      prod_r <= op_tag.mac ? PROD_W'(op_mat * op_vec) : '0;
    end
  end

  // accumulate stage, restarts on the first column of each row
  assign prod_ext = DOT_W'(prod_r);
  assign acc_sum  = tag2_r.first ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (en && s2_v_r) begin
      acc_r <= acc_sum;
    end
  end

  assign res.valid = s2_v_r && tag2_r.lastcol;
  assign res.last  = tag2_r.lastrow;
  assign res.row   = tag2_r.row;
  assign res.dot   = acc_sum;

endmodule

// ===== hw/rtl/persymmetric_triangular_matvec.sv =====
// loads (matrix entry, vector element) are taken one per cycle while in_stall is low
// compute: row results pass operand and multiply stages into the output register;
// the walk covers MAX_N columns per row; in_stall holds until the last result registers
// a stalled output freezes the whole compute pipeline until the result is taken
// reset: matrix_size returns to 16 and control clears; the matrix and vector
// stores are undefined until loaded and get no clearing pass
`include "persymmetric_triangular_matvec_macros.svh"

module persymmetric_triangular_matvec import ptm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [4:0]              cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_action,
  input  logic [3:0]              in_row,
  input  logic [3:0]              in_col,
  input  logic signed [15:0]      in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              out_result_row,
  output logic signed [35:0]      out_dot_product,
  output logic                    out_last
);

  logic [4:0]          size_r;
  logic [N_W-1:0]      n_eff;
  logic                busy_r;
  logic                seq_act_r;
  logic [IDX_W-1:0]    r_r;
  logic [IDX_W-1:0]    c_r;
  logic                s1_v_r;
  tag_t                tag1_r;
  tag_t                tag_cur;
  logic [VAL_W-1:0]    rd_r;
  logic [VAL_W-1:0]    vec1_r;
  logic [VAL_W-1:0]    mem [DEPTH];
  logic [VAL_W-1:0]    cell_val [MAX_N];
  logic                en;
  logic                in_acc;
  logic                mat_wr;
  logic                vec_wr;
  logic                cmp_go;
  logic                col_end;
  logic                row_end;
  logic [N_W-1:0]      rc_sum;
  logic [N_W-1:0]      ld_sum;
  logic                mirror;
  logic [N_W-1:0]      sr_w;
  logic [N_W-1:0]      sc_w;
  logic [ADDR_W-1:0]   rd_addr;
  res_t                res;
  logic                out_valid_r;
  logic                out_last_r;
  logic [IDX_W-1:0]    out_row_r;
  logic [DOT_W-1:0]    out_dot_r;

  // size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 5'd16;
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  // clamp size into 1..MAX_N
  always_comb begin
    if (size_r == '0) begin
      n_eff = N_W'(1);
    end else if (N_W'(size_r) > N_W'(MAX_N)) begin
      n_eff = N_W'(MAX_N);
    end else begin
      n_eff = N_W'(size_r);
    end
  end

  // input decode
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign ld_sum   = {1'b0, in_row} + {1'b0, in_col};

  always_comb begin
    mat_wr = 1'b0;
    vec_wr = 1'b0;
    cmp_go = 1'b0;
    unique case (in_action)
      ACT_LOAD_MAT: mat_wr = in_acc && (in_col <= in_row) && (ld_sum < n_eff);
      ACT_LOAD_VEC: vec_wr = in_acc;
      ACT_COMPUTE:  cmp_go = in_acc;
      default: ;
    endcase
  end

  // row and column sequencer
  assign col_end = (c_r == IDX_W'(MAX_N - 1));
  assign row_end = (r_r == IDX_W'(n_eff - N_W'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_act_r <= 1'b0;
      busy_r    <= 1'b0;
      r_r       <= '0;
      c_r       <= '0;
    end else begin
      if (cmp_go) begin
        seq_act_r <= 1'b1;
        busy_r    <= 1'b1;
        r_r       <= '0;
        c_r       <= '0;
      end else begin
        if (en && seq_act_r) begin
          c_r <= c_r + IDX_W'(1);
          if (col_end) begin
            if (row_end) begin
              seq_act_r <= 1'b0;
            end else begin
              r_r <= r_r + IDX_W'(1);
            end
          end
        end
        if (en && res.valid && res.last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // element address, mirrored across the anti-diagonal when row + col >= n
  assign rc_sum  = {1'b0, r_r} + {1'b0, c_r};
  assign mirror  = (rc_sum >= n_eff);
  assign sr_w    = n_eff - N_W'(1) - {1'b0, c_r};
  assign sc_w    = n_eff - N_W'(1) - {1'b0, r_r};
  assign rd_addr = mirror ? {sr_w[IDX_W-1:0], sc_w[IDX_W-1:0]} : {r_r, c_r};

  assign tag_cur.mac     = (c_r <= r_r) && (N_W'(c_r) < n_eff);
  assign tag_cur.first   = (c_r == '0);
  assign tag_cur.lastcol = col_end;
  assign tag_cur.lastrow = row_end;
  assign tag_cur.row     = r_r;

  // matrix store
  always_ff @(posedge clk) begin
    if (mat_wr) begin
      mem[{in_row, in_col}] <= in_value;
    end
    if (en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // vector ring, rotates one place per column step
  for (genvar i = 0; i < MAX_N; i++) begin : g_cell
    ptm_vec_cell u_cell (
      .clk      (clk),
      .load_en  (vec_wr && (in_col == IDX_W'(i))),
      .load_val (in_value),
      .shift_en (en && seq_act_r),
      .shift_in (cell_val[(i + 1) % MAX_N]),
      .val      (cell_val[i])
    );
  end

  // operand stage aligned with the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= seq_act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r <= tag_cur;
      vec1_r <= cell_val[0];
    end
  end

  ptm_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .op_valid (s1_v_r),
    .op_tag   (tag1_r),
    .op_mat   (rd_r),
    .op_vec   (vec1_r),
    .res      (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && res.valid) begin
      out_row_r  <= res.row;
      out_last_r <= res.last;
      out_dot_r  <= res.dot;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_row  = out_row_r;
  assign out_last        = out_last_r;
  assign out_dot_product = out_dot_r;

  // checks
  `PTM_ASSERT(a_busy_ends_on_last, $fell(busy_r) |-> out_valid_r && out_last_r, "busy cleared without last result")
  `PTM_ASSERT(a_res_only_busy, res.valid |-> busy_r, "row result outside a compute")
  `PTM_ASSERT(a_go_starts_seq, cmp_go |=> seq_act_r && busy_r && (c_r == '0) && (r_r == '0), "compute did not start the walk")
  `PTM_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |=> !busy_r && !seq_act_r && !out_valid_r, "control not cleared by reset")

endmodule
